@@ hdl/wfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_pkg
// Shared types and constants for the waypoint-following P controller.
// ----------------------------------------------------------------------------
package wfp_pkg;

  localparam int NUM_WAYPOINTS = 4;
  localparam int CORDIC_STEPS  = 14;

  // angle constants
  localparam logic signed [21:0] PI_Q16     = 22'sd205887;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

  // config register reset values
  localparam logic [15:0] SPEED_GAIN_RST = 16'd410;
  localparam logic [15:0] TURN_GAIN_RST  = 16'd2048;
  localparam logic [14:0] THRESH_RST     = 15'd410;
  localparam logic [14:0] MAX_LIN_RST    = 15'd819;
  localparam logic [14:0] MAX_ANG_RST    = 15'd819;
  localparam logic [2:0]  PATH_LEN_RST   = 3'd4;
  localparam logic [63:0] WP_LO_RST      = 64'd461063047062162637;
  localparam logic [63:0] WP_HI_RST      = 64'd80546202;

  // register indexes (byte address = 8 * index)
  typedef enum logic [2:0] {
    REG_SPEED_GAIN = 3'd0,
    REG_TURN_GAIN  = 3'd1,
    REG_THRESH     = 3'd2,
    REG_MAX_LIN    = 3'd3,
    REG_MAX_ANG    = 3'd4,
    REG_PATH_LEN   = 3'd5,
    REG_WP_LO      = 3'd6,
    REG_WP_HI      = 3'd7
  } wfp_reg_t;

  typedef struct packed {
    logic [15:0] speed_gain;
    logic [15:0] turn_gain;
    logic [14:0] reach_threshold;
    logic [14:0] max_linear;
    logic [14:0] max_angular;
    logic [2:0]  path_length;
    logic [63:0] waypoints_lo;
    logic [63:0] waypoints_hi;
  } wfp_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_O_MUL0,
    ST_O_MUL1,
    ST_O_MUL2,
    ST_O_MUL3,
    ST_O_MUL4,
    ST_T_CHK,
    ST_T_SQ0,
    ST_T_SQ1,
    ST_T_SQ2,
    ST_SQRT,
    ST_T_CMP,
    ST_T_LIN,
    ST_C_INIT,
    ST_C_ITER,
    ST_C_END,
    ST_T_ANG,
    ST_T_ANGC,
    ST_OUT
  } wfp_state_t;

  // atan(2^-i) in Q16
  function automatic logic signed [21:0] atan_q16(input logic [3:0] i);
    logic signed [21:0] v;
    case (i)
      4'd0:    v = 22'sd51472;
      4'd1:    v = 22'sd30386;
      4'd2:    v = 22'sd16055;
      4'd3:    v = 22'sd8150;
      4'd4:    v = 22'sd4091;
      4'd5:    v = 22'sd2047;
      4'd6:    v = 22'sd1024;
      4'd7:    v = 22'sd512;
      4'd8:    v = 22'sd256;
      4'd9:    v = 22'sd128;
      4'd10:   v = 22'sd64;
      4'd11:   v = 22'sd32;
      4'd12:   v = 22'sd16;
      4'd13:   v = 22'sd8;
      4'd14:   v = 22'sd4;
      default: v = 22'sd2;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/wfp_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_cfg_regs
// APB-style register file holding gains, limits and the waypoint table.
// ----------------------------------------------------------------------------
module wfp_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [5:0]       cfg_paddr,
  input  logic [63:0]      cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready,
  output wfp_pkg::wfp_cfg_t cfg
);

  wfp_pkg::wfp_cfg_t cfg_r, cfg_nxt;
  wfp_pkg::wfp_reg_t idx;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = wfp_pkg::wfp_reg_t'(cfg_paddr[5:3]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        wfp_pkg::REG_SPEED_GAIN: cfg_nxt.speed_gain      = cfg_pwdata[15:0];
        wfp_pkg::REG_TURN_GAIN:  cfg_nxt.turn_gain       = cfg_pwdata[15:0];
        wfp_pkg::REG_THRESH:     cfg_nxt.reach_threshold = cfg_pwdata[14:0];
        wfp_pkg::REG_MAX_LIN:    cfg_nxt.max_linear      = cfg_pwdata[14:0];
        wfp_pkg::REG_MAX_ANG:    cfg_nxt.max_angular     = cfg_pwdata[14:0];
        wfp_pkg::REG_PATH_LEN:   cfg_nxt.path_length     = cfg_pwdata[2:0];
        wfp_pkg::REG_WP_LO:      cfg_nxt.waypoints_lo    = cfg_pwdata;
        wfp_pkg::REG_WP_HI:      cfg_nxt.waypoints_hi    = cfg_pwdata;
        default:                 cfg_nxt                 = cfg_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      wfp_pkg::REG_SPEED_GAIN: cfg_prdata = {48'd0, cfg_r.speed_gain};
      wfp_pkg::REG_TURN_GAIN:  cfg_prdata = {48'd0, cfg_r.turn_gain};
      wfp_pkg::REG_THRESH:     cfg_prdata = {49'd0, cfg_r.reach_threshold};
      wfp_pkg::REG_MAX_LIN:    cfg_prdata = {49'd0, cfg_r.max_linear};
      wfp_pkg::REG_MAX_ANG:    cfg_prdata = {49'd0, cfg_r.max_angular};
      wfp_pkg::REG_PATH_LEN:   cfg_prdata = {61'd0, cfg_r.path_length};
      wfp_pkg::REG_WP_LO:      cfg_prdata = cfg_r.waypoints_lo;
      wfp_pkg::REG_WP_HI:      cfg_prdata = cfg_r.waypoints_hi;
      default:                 cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_gain      <= wfp_pkg::SPEED_GAIN_RST;
      cfg_r.turn_gain       <= wfp_pkg::TURN_GAIN_RST;
      cfg_r.reach_threshold <= wfp_pkg::THRESH_RST;
      cfg_r.max_linear      <= wfp_pkg::MAX_LIN_RST;
      cfg_r.max_angular     <= wfp_pkg::MAX_ANG_RST;
      cfg_r.path_length     <= wfp_pkg::PATH_LEN_RST;
      cfg_r.waypoints_lo    <= wfp_pkg::WP_LO_RST;
      cfg_r.waypoints_hi    <= wfp_pkg::WP_HI_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/waypoint_follow_p_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_follow_p_controller_unit
// Go-to-goal P controller: odometry stores pose and heading, ticks steer to
// the current waypoint. One 18x18 multiplier, a CORDIC and a root unit are
// shared under one sequencer.
// ----------------------------------------------------------------------------
// Channel  | Dir | Payload
// in_      | in  | tdata: pos_x, pos_y, quat_x, quat_y, quat_z, quat_w; tuser: req_type
// out_     | out | tdata: linear_cmd, angular_cmd, target_index; tuser: reached, path_done
// cfg_     | in  | APB registers, 64-bit data, byte address 8 * index
//
// An odometry transaction runs its multiplies and 14 CORDIC steps; a tick runs
// two squares, 17 root steps, gain multiplies and 14 CORDIC steps; a path-done
// tick or a reached tick ends early.
// in_tready is high only while idle; a finished result sits in the output
// register, so a stalled out_ side holds the sequencer only at its last step.
// Synchronous reset clears control state and restores register defaults.
module waypoint_follow_p_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // linear_cmd, angular_cmd, target_index, zero pad
  output logic [1:0]  out_tuser,  // reached, path_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  wfp_pkg::wfp_cfg_t cfg;

  wfp_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // single wrap by 2pi into [-pi, pi]
  function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] r;
    if (a > wfp_pkg::PI_Q12)       r = a - wfp_pkg::TWO_PI_Q12;
    else if (a < -wfp_pkg::PI_Q12) r = a + wfp_pkg::TWO_PI_Q12;
    else                           r = a;
    return r[15:0];
  endfunction

  wfp_pkg::wfp_state_t state_r, state_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic                tick_r, tick_nxt;
  logic signed [15:0]  qx_r, qy_r, qz_r, qw_r, qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic signed [15:0]  pose_x_r, pose_y_r, heading_r;
  logic signed [15:0]  pose_x_nxt, pose_y_nxt, heading_nxt;
  logic [2:0]          ptr_r, ptr_nxt;
  logic signed [16:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [35:0]  prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [36:0]  cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [21:0]  z_r, z_nxt;
  logic [33:0]         rad_r, rad_nxt;
  logic [34:0]         root_r, root_nxt, bit_r, bit_nxt;
  logic [14:0]         lin_r, lin_nxt;
  logic signed [15:0]  err_r, err_nxt;
  logic [14:0]         res_lin_r, res_lin_nxt;
  logic signed [15:0]  res_ang_r, res_ang_nxt;
  logic                res_reach_r, res_reach_nxt, res_done_r, res_done_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [39:0]         out_data_r, out_data_nxt;
  logic [1:0]          out_user_r, out_user_nxt;

  // shared multiplier operands
  logic signed [17:0]  mul_a, mul_b;

  // combinational helpers
  logic [2:0]          eff_len;
  logic [1:0]          wp;
  logic [63:0]         wp_reg;
  logic signed [15:0]  wp_x, wp_y;
  logic signed [36:0]  sum37, xs, ys;
  logic [34:0]         trial;
  logic signed [21:0]  zr;
  logic signed [15:0]  ang_w;
  logic signed [23:0]  gain_q;
  logic signed [23:0]  max_ang_s;

  assign in_tready  = (state_r == wfp_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    eff_len = (cfg.path_length > 3'(wfp_pkg::NUM_WAYPOINTS))
              ? 3'(wfp_pkg::NUM_WAYPOINTS) : cfg.path_length;
    wp      = ptr_r[1:0];
    wp_reg  = wp[1] ? cfg.waypoints_hi : cfg.waypoints_lo;
    wp_x    = wp[0] ? wp_reg[47:32] : wp_reg[15:0];
    wp_y    = wp[0] ? wp_reg[63:48] : wp_reg[31:16];
    sum37   = 37'(acc_r) + 37'(prod_r);
    xs      = cx_r >>> cnt_r;
    ys      = cy_r >>> cnt_r;
    trial   = root_r + bit_r;
    zr      = z_r + 22'sd8;
    ang_w   = wrap_ang(zr[21:4]);
    gain_q  = prod_r[35:12];
    max_ang_s = {9'd0, cfg.max_angular};
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qz_nxt        = qz_r;
    qw_nxt        = qw_r;
    pose_x_nxt    = pose_x_r;
    pose_y_nxt    = pose_y_r;
    heading_nxt   = heading_r;
    ptr_nxt       = ptr_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    acc_nxt       = acc_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    z_nxt         = z_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    lin_nxt       = lin_r;
    err_nxt       = err_r;
    res_lin_nxt   = res_lin_r;
    res_ang_nxt   = res_ang_r;
    res_reach_nxt = res_reach_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mul_a         = 18'sd0;
    mul_b         = 18'sd0;

    unique case (state_r)
      wfp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          tick_nxt = in_tuser;
          if (in_tuser) begin
            state_nxt = wfp_pkg::ST_T_CHK;
          end else begin
            pose_x_nxt = in_tdata[15:0];
            pose_y_nxt = in_tdata[31:16];
            qx_nxt     = in_tdata[47:32];
            qy_nxt     = in_tdata[63:48];
            qz_nxt     = in_tdata[79:64];
            qw_nxt     = in_tdata[95:80];
            state_nxt  = wfp_pkg::ST_O_MUL0;
          end
        end
      end
      // sin term: 2(wz + xy), cos term: 2^28 - 2(y^2 + z^2)
      wfp_pkg::ST_O_MUL0: begin
        mul_a = 18'(qw_r); mul_b = 18'(qz_r);
        state_nxt = wfp_pkg::ST_O_MUL1;
      end
      wfp_pkg::ST_O_MUL1: begin
        acc_nxt = prod_r;
        mul_a = 18'(qx_r); mul_b = 18'(qy_r);
        state_nxt = wfp_pkg::ST_O_MUL2;
      end
      wfp_pkg::ST_O_MUL2: begin
        cy_nxt = sum37 <<< 1;
        mul_a = 18'(qy_r); mul_b = 18'(qy_r);
        state_nxt = wfp_pkg::ST_O_MUL3;
      end
      wfp_pkg::ST_O_MUL3: begin
        acc_nxt = prod_r;
        mul_a = 18'(qz_r); mul_b = 18'(qz_r);
        state_nxt = wfp_pkg::ST_O_MUL4;
      end
      wfp_pkg::ST_O_MUL4: begin
        cx_nxt = (37'sd1 <<< 28) - (sum37 <<< 1);
        state_nxt = wfp_pkg::ST_C_INIT;
      end
      // tick: path check and offsets to waypoint
      wfp_pkg::ST_T_CHK: begin
        if (ptr_r >= eff_len) begin
          res_lin_nxt   = '0;
          res_ang_nxt   = '0;
          res_reach_nxt = 1'b0;
          res_done_nxt  = 1'b1;
          state_nxt     = wfp_pkg::ST_OUT;
        end else begin
          dx_nxt    = 17'(wp_x) - 17'(pose_x_r);
          dy_nxt    = 17'(wp_y) - 17'(pose_y_r);
          state_nxt = wfp_pkg::ST_T_SQ0;
        end
      end
      wfp_pkg::ST_T_SQ0: begin
        mul_a = 18'(dx_r); mul_b = 18'(dx_r);
        state_nxt = wfp_pkg::ST_T_SQ1;
      end
      wfp_pkg::ST_T_SQ1: begin
        acc_nxt = prod_r;
        mul_a = 18'(dy_r); mul_b = 18'(dy_r);
        state_nxt = wfp_pkg::ST_T_SQ2;
      end
      wfp_pkg::ST_T_SQ2: begin
        rad_nxt   = sum37[33:0];
        root_nxt  = '0;
        bit_nxt   = 35'd1 << 32;
        state_nxt = wfp_pkg::ST_SQRT;
      end
      // one digit of the integer root per cycle
      wfp_pkg::ST_SQRT: begin
        if ({1'b0, rad_r} >= trial) begin
          rad_nxt  = rad_r - trial[33:0];
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[1:0] != 2'b00 || bit_r == 35'd0) state_nxt = wfp_pkg::ST_T_CMP;
      end
      wfp_pkg::ST_T_CMP: begin
        if (root_r < {20'd0, cfg.reach_threshold}) begin
          ptr_nxt       = ptr_r + 3'd1;
          res_lin_nxt   = '0;
          res_ang_nxt   = '0;
          res_reach_nxt = 1'b1;
          res_done_nxt  = 1'b0;
          state_nxt     = wfp_pkg::ST_OUT;
        end else begin
          mul_a = {2'b00, cfg.speed_gain};
          mul_b = {1'b0, root_r[16:0]};
          state_nxt = wfp_pkg::ST_T_LIN;
        end
      end
      wfp_pkg::ST_T_LIN: begin
        lin_nxt = (gain_q > {9'd0, cfg.max_linear}) ? cfg.max_linear : gain_q[14:0];
        cx_nxt  = 37'(dx_r) <<< 14;
        cy_nxt  = 37'(dy_r) <<< 14;
        state_nxt = wfp_pkg::ST_C_INIT;
      end
      // CORDIC setup: zero-vector shortcut and half-plane fold
      wfp_pkg::ST_C_INIT: begin
        cnt_nxt = '0;
        z_nxt   = '0;
        if (cx_r == 37'sd0 && cy_r == 37'sd0) begin
          z_nxt     = -22'sd8;
          state_nxt = wfp_pkg::ST_C_END;
        end else begin
          if (cx_r < 0) begin
            z_nxt  = (cy_r >= 0) ? wfp_pkg::PI_Q16 : -wfp_pkg::PI_Q16;
            cx_nxt = -cx_r;
            cy_nxt = -cy_r;
          end
          state_nxt = wfp_pkg::ST_C_ITER;
        end
      end
      wfp_pkg::ST_C_ITER: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          z_nxt  = z_r + wfp_pkg::atan_q16(cnt_r);
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          z_nxt  = z_r - wfp_pkg::atan_q16(cnt_r);
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(wfp_pkg::CORDIC_STEPS - 1)) state_nxt = wfp_pkg::ST_C_END;
      end
      wfp_pkg::ST_C_END: begin
        if (tick_r) begin
          err_nxt   = wrap_ang(18'(ang_w) - 18'(heading_r));
          state_nxt = wfp_pkg::ST_T_ANG;
        end else begin
          heading_nxt = ang_w;
          state_nxt   = wfp_pkg::ST_IDLE;
        end
      end
      wfp_pkg::ST_T_ANG: begin
        mul_a = {2'b00, cfg.turn_gain};
        mul_b = 18'(err_r);
        state_nxt = wfp_pkg::ST_T_ANGC;
      end
      wfp_pkg::ST_T_ANGC: begin
        if (gain_q > max_ang_s)       res_ang_nxt = max_ang_s[15:0];
        else if (gain_q < -max_ang_s) res_ang_nxt = 16'(-max_ang_s);
        else                          res_ang_nxt = gain_q[15:0];
        res_lin_nxt   = lin_r;
        res_reach_nxt = 1'b0;
        res_done_nxt  = 1'b0;
        state_nxt     = wfp_pkg::ST_OUT;
      end
      // hand the result to the output register once it is free
      wfp_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, ptr_r, res_ang_r, res_lin_r};
          out_user_nxt  = {res_done_r, res_reach_r};
          state_nxt     = wfp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wfp_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      pose_x_r    <= pose_x_nxt;
      pose_y_r    <= pose_y_nxt;
      heading_r   <= heading_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    tick_r      <= tick_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    qz_r        <= qz_nxt;
    qw_r        <= qw_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    z_r         <= z_nxt;
    rad_r       <= rad_nxt;
    root_r      <= root_nxt;
    bit_r       <= bit_nxt;
    lin_r       <= lin_nxt;
    err_r       <= err_nxt;
    res_lin_r   <= res_lin_nxt;
    res_ang_r   <= res_ang_nxt;
    res_reach_r <= res_reach_nxt;
    res_done_r  <= res_done_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the waypoint-following P controller. A command
// scoreboard keeps its own copy of the registers, the pose and the waypoint
// index. It predicts every velocity command from the accepted odometry and
// tick transactions, then compares each command the block returns field by
// field. The bench first runs directed cases, then random phases under
// several register settings, with bursty input and stalls on the output side.
// ----------------------------------------------------------------------------

typedef struct {
  logic [14:0]        lin;
  logic signed [15:0] ang;
  logic               reached;
  logic               done;
  logic [2:0]         idx;
} cmd_t;

class cmd_scoreboard;
  // atan(2^-i), Q16
  localparam longint ATAN_TAB [14] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                       512, 256, 128, 64, 32, 16, 8};
  localparam longint HALF_TURN_Q16 = 205887;
  localparam longint HALF_TURN     = 12868;
  localparam longint FULL_TURN     = 25736;

  logic [15:0] speed_gain, turn_gain;
  logic [14:0] thresh, max_lin, max_ang;
  logic [2:0]  path_len;
  logic [63:0] wp_lo, wp_hi;
  longint      px, py, hdg;
  int unsigned wp_idx;
  cmd_t        pending[$];
  int          errors;

  function new();
    speed_gain = wfp_pkg::SPEED_GAIN_RST;
    turn_gain  = wfp_pkg::TURN_GAIN_RST;
    thresh     = wfp_pkg::THRESH_RST;
    max_lin    = wfp_pkg::MAX_LIN_RST;
    max_ang    = wfp_pkg::MAX_ANG_RST;
    path_len   = wfp_pkg::PATH_LEN_RST;
    wp_lo      = wfp_pkg::WP_LO_RST;
    wp_hi      = wfp_pkg::WP_HI_RST;
    px = 0; py = 0; hdg = 0; wp_idx = 0; errors = 0;
  endfunction

  function void set_reg(wfp_pkg::wfp_reg_t r, logic [63:0] v);
    case (r)
      wfp_pkg::REG_SPEED_GAIN: speed_gain = v[15:0];
      wfp_pkg::REG_TURN_GAIN:  turn_gain  = v[15:0];
      wfp_pkg::REG_THRESH:     thresh     = v[14:0];
      wfp_pkg::REG_MAX_LIN:    max_lin    = v[14:0];
      wfp_pkg::REG_MAX_ANG:    max_ang    = v[14:0];
      wfp_pkg::REG_PATH_LEN:   path_len   = v[2:0];
      wfp_pkg::REG_WP_LO:      wp_lo      = v;
      default:                 wp_hi      = v;
    endcase
  endfunction

  function longint wp_coord(int k);
    logic [63:0] r;
    r = (k < 4) ? wp_lo : wp_hi;
    return longint'($signed(r[16*(k%4) +: 16]));
  endfunction

  function longint wrap(longint a);
    if (a > HALF_TURN) return a - FULL_TURN;
    if (a < -HALF_TURN) return a + FULL_TURN;
    return a;
  endfunction

  // vectoring rotation, Q16 accumulator, rounded to Q12
  function longint bearing(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_TAB[i];
      end
    end
    return wrap((z + 8) >>> 4);
  endfunction

  function longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // accepted input transaction: update pose or queue the expected command
  function void note_item(logic req, logic [95:0] d);
    longint qx, qy, qz, qw, dx, dy, lin, ang, err;
    longint unsigned span;
    int unsigned len;
    cmd_t c;
    if (!req) begin
      qx = $signed(d[47:32]); qy = $signed(d[63:48]);
      qz = $signed(d[79:64]); qw = $signed(d[95:80]);
      px = $signed(d[15:0]);
      py = $signed(d[31:16]);
      hdg = bearing(2 * (qw * qz + qx * qy), (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
      return;
    end
    len = (path_len > 4) ? 4 : path_len;
    c.lin = 0; c.ang = 0; c.reached = 0; c.done = 0;
    if (wp_idx >= len) begin
      c.done = 1;
    end else begin
      dx = wp_coord(2 * (wp_idx % 4)) - px;
      dy = wp_coord(2 * (wp_idx % 4) + 1) - py;
      span = root(longint'(dx * dx + dy * dy));
      if (span < thresh) begin
        wp_idx++;
        c.reached = 1;
      end else begin
        lin = longint'((longint'(speed_gain) * span) >> 12);
        if (lin > max_lin) lin = max_lin;
        err = wrap(bearing(dy * 16384, dx * 16384) - hdg);
        ang = (longint'(turn_gain) * err) >>> 12;
        if (ang > longint'(max_ang)) ang = max_ang;
        if (ang < -longint'(max_ang)) ang = -longint'(max_ang);
        c.lin = lin[14:0];
        c.ang = ang[15:0];
      end
    end
    c.idx = wp_idx[2:0];
    pending.push_back(c);
  endfunction

  function void check_cmd(logic [39:0] d, logic [1:0] u);
    cmd_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected command tdata=%h tuser=%b", $time, d, u);
      return;
    end
    e = pending.pop_front();
    if (d[14:0] !== e.lin) begin
      errors++;
      $display("%0t: linear_cmd exp %0d got %0d", $time, e.lin, d[14:0]);
    end
    if (d[30:15] !== e.ang) begin
      errors++;
      $display("%0t: angular_cmd exp %0d got %0d", $time, e.ang, $signed(d[30:15]));
    end
    if (d[33:31] !== e.idx) begin
      errors++;
      $display("%0t: target_index exp %0d got %0d", $time, e.idx, d[33:31]);
    end
    if (u[0] !== e.reached) begin
      errors++;
      $display("%0t: reached exp %b got %b", $time, e.reached, u[0]);
    end
    if (u[1] !== e.done) begin
      errors++;
      $display("%0t: path_done exp %b got %b", $time, e.done, u[1]);
    end
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  cmd_scoreboard sb;
  int burst_left;
  int stall_cnt;

  waypoint_follow_p_controller_unit dut (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // result side: check each command transaction, stall on its own pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_cmd(out_tdata, out_tuser);
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) < 2) stall_cnt <= $urandom_range(1, 20);
    end
  end

  task automatic write_reg(wfp_pkg::wfp_reg_t r, logic [63:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {r, 3'b000}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  // wait for every expected command, then let any odometry work finish
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // valid drops after each acceptance; the block stays busy until it is idle again
  task automatic send(logic req, logic [95:0] d);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    sb.note_item(req, d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_quat();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic odom(logic [15:0] x, logic [15:0] y, logic [15:0] qx, logic [15:0] qy,
                      logic [15:0] qz, logic [15:0] qw);
    send(1'b0, {qw, qz, qy, qx, y, x});
  endtask

  task automatic tick();
    send(1'b1, 96'($urandom()));
  endtask

  // odometry placed on or near the current waypoint
  task automatic odom_near(int spread);
    int k;
    k = 2 * (sb.wp_idx % 4);
    odom(16'(sb.wp_coord(k) + $signed($urandom_range(0, 2 * spread)) - spread),
         16'(sb.wp_coord(k + 1) + $signed($urandom_range(0, 2 * spread)) - spread),
         rnd_quat(), rnd_quat(), rnd_quat(), rnd_quat());
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) tick();
      else if ($urandom_range(0, 19) == 0) odom_near(300);
      else odom(16'($urandom()), 16'($urandom()), rnd_quat(), rnd_quat(), rnd_quat(),
                rnd_quat());
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0; stall_cnt = 0; burst_left = 0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of pose and quaternion, zero vector, identity
    tick();
    odom(16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h4000, 16'hC000);
    tick();
    odom(16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'hC000, 16'h4000);
    tick();
    odom(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
    tick();
    odom(16'h1234, 16'hFEDC, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
    tick();
    odom(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    tick();
    drain();
    // zero threshold: sitting on the waypoint is still not a reach
    write_reg(wfp_pkg::REG_THRESH, 64'd0);
    odom_near(0);
    tick();
    drain();
    write_reg(wfp_pkg::REG_THRESH, 64'd410);
    tick();
    odom_near(100);
    tick();
    drain();
    // empty path reports done
    write_reg(wfp_pkg::REG_PATH_LEN, 64'd0);
    tick();
    tick();
    drain();
    write_reg(wfp_pkg::REG_PATH_LEN, 64'd4);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(wfp_pkg::REG_SPEED_GAIN, 64'd65535);
          write_reg(wfp_pkg::REG_TURN_GAIN, 64'd65535);
          write_reg(wfp_pkg::REG_THRESH, 64'd0);
          write_reg(wfp_pkg::REG_MAX_LIN, 64'd32767);
          write_reg(wfp_pkg::REG_MAX_ANG, 64'd32767);
          write_reg(wfp_pkg::REG_PATH_LEN, 64'd7);
          write_reg(wfp_pkg::REG_WP_LO, {$urandom(), $urandom()});
          write_reg(wfp_pkg::REG_WP_HI, {$urandom(), $urandom()});
        end
        2: begin
          write_reg(wfp_pkg::REG_SPEED_GAIN, 64'd0);
          write_reg(wfp_pkg::REG_TURN_GAIN, 64'd0);
          write_reg(wfp_pkg::REG_MAX_LIN, 64'd0);
          write_reg(wfp_pkg::REG_MAX_ANG, 64'd0);
          write_reg(wfp_pkg::REG_THRESH, 64'd200);
        end
        3, 5: begin
          write_reg(wfp_pkg::REG_SPEED_GAIN, 64'($urandom_range(0, 65535)));
          write_reg(wfp_pkg::REG_TURN_GAIN, 64'($urandom_range(0, 65535)));
          write_reg(wfp_pkg::REG_MAX_LIN, 64'($urandom_range(0, 32767)));
          write_reg(wfp_pkg::REG_MAX_ANG, 64'($urandom_range(0, 32767)));
          write_reg(wfp_pkg::REG_THRESH, 64'($urandom_range(0, 1000)));
          write_reg(wfp_pkg::REG_PATH_LEN, 64'($urandom_range(3, 7)));
          write_reg(wfp_pkg::REG_WP_HI, {$urandom(), $urandom()});
        end
        4: write_reg(wfp_pkg::REG_PATH_LEN, 64'd0);
        6: write_reg(wfp_pkg::REG_PATH_LEN, 64'd4);
        7: write_reg(wfp_pkg::REG_THRESH, 64'd32767);
        default: ;
      endcase
      random_phase(45);
      // hold the input until every command is back
      if (ph == 3) drain();
      random_phase(45);
    end

    in_tvalid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** waypoint_follow_p_controller_unit: PASSED **");
    end else begin
      $display("** waypoint_follow_p_controller_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** waypoint_follow_p_controller_unit: FAILED **");
    $finish;
  end
endmodule

@@ files.f @@
hdl/wfp_pkg.sv
hdl/wfp_cfg_regs.sv
hdl/waypoint_follow_p_controller_unit.sv
tb/tb.sv
